### design/geodesic_interval_distance_unit_defines.svh
// ----------------------------------------------------------------------------
// Geodesic interval distance unit assertion macros
// Shared property forms used by the checker of the distance unit.
// ----------------------------------------------------------------------------
`ifndef GEODESIC_INTERVAL_DISTANCE_UNIT_DEFINES_SVH
`define GEODESIC_INTERVAL_DISTANCE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GIDU_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("gidu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GIDU_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("gidu: next-cycle check failed");

// Checked through reset as well.
`define GIDU_ASSERT_RESET(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error("gidu: reset check failed");

`endif

### design/gidu_pkg.sv
// ----------------------------------------------------------------------------
// Geodesic interval distance unit package
// Beat types, codes and datapath widths shared by the unit's files.
// ----------------------------------------------------------------------------
`default_nettype none

package gidu_pkg;

  localparam logic [1:0] OP_POINT   = 2'd0;
  localparam logic [1:0] OP_MAX     = 2'd1;
  localparam logic [1:0] OP_MIN     = 2'd2;
  localparam logic [1:0] OP_CLOSEST = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_OUTSIDE = 2'd2;

  localparam logic [31:0] EPS_RESET = 32'd4295;

  localparam int NUM_W  = 64;
  localparam int DEN_W  = 33;
  localparam int ARG_W  = 34;
  localparam int ROOT_W = 36;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int SREM_W = ROOT_W + 2;
  localparam int SUM_W  = 38;

  typedef struct packed {
    logic [1:0]         opcode;
    logic               window_infinite;
    logic [31:0]        base_distance;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic [30:0]        seg_start;
    logic [30:0]        seg_end;
    logic [30:0]        edge_len;
    logic signed [31:0] query_x;
    logic signed [31:0] query_h;
  } item_t;

  typedef struct packed {
    logic [31:0]        distance;
    logic signed [31:0] closest_offset;
    logic               is_infinite;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] den;
  } div_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    item_t item;
    logic  deg;
    logic  qneg;
  } ctx_t;

  typedef struct packed {
    logic             inf;
    logic [1:0]       opcode;
    logic [31:0]      base;
    logic [ARG_W-1:0] lin;
    logic [31:0]      r;
    logic             outside;
  } ctx2_t;

endpackage

`default_nettype wire

### design/gidu_if.sv
// ----------------------------------------------------------------------------
// Geodesic interval distance unit channels
// Valid/ready channels for query beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface gidu_item_if;
  import gidu_pkg::*;
  logic  valid;
  logic  ready;
  item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface gidu_result_if;
  import gidu_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

`default_nettype wire

### design/gidu_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit per cell; hands the partial state onward.
// ----------------------------------------------------------------------------
`default_nettype none

module gidu_div_cell (
  input  logic           clk,
  input  logic           en,
  input  gidu_pkg::div_t d_in,
  output gidu_pkg::div_t d_out
);
  import gidu_pkg::*;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           take;

  always_comb begin
    trial = {d_in.rem, d_in.nq[NUM_W-1]};
    diff  = trial - {1'b0, d_in.den};
    take  = trial >= {1'b0, d_in.den};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rem <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      d_out.nq  <= {d_in.nq[NUM_W-2:0], take};
      d_out.den <= d_in.den;
    end
  end

endmodule

`default_nettype wire

### design/gidu_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One root bit per cell of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module gidu_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  gidu_pkg::sqrt_t d_in,
  output gidu_pkg::sqrt_t d_out
);
  import gidu_pkg::*;

  logic [SREM_W+1:0] t;
  logic [SREM_W+1:0] trial;
  logic [SREM_W+1:0] diff;
  logic              take;

  always_comb begin
    t     = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
    trial = {2'b00, d_in.root, 2'b01};
    diff  = t - trial;
    take  = t >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out.rad  <= {d_in.rad[RAD_W-3:0], 2'b00};
      d_out.rem  <= take ? diff[SREM_W-1:0] : t[SREM_W-1:0];
      d_out.root <= {d_in.root[ROOT_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

### design/geodesic_interval_distance_unit.sv
// ----------------------------------------------------------------------------
// Geodesic interval distance unit
// Evaluates one exact-geodesic window per beat for four query opcodes.
// ----------------------------------------------------------------------------
// The unit takes query beats on item and returns one result beat per query on
// result, in order. Both channels transfer a beat when valid and ready are
// high at a rising edge of clk. The epsilon ratio register is loaded from
// epsilon_wdata whenever epsilon_we is high; it should be written only while
// no query is in flight.
// The unit takes one query every cycle while result is not held back: the
// pipeline is a 64-cell divider chain for the closest point quotient followed
// by two parallel 36-cell square root chains, with three stages in front and
// three between and after.
// Reset clears every stage valid flag and loads the epsilon ratio with its
// default; no result is offered until a new query has passed through.
// While result is held back, the whole pipeline freezes and item.ready is low;
// the pending result beat stays on the port unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module geodesic_interval_distance_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  gidu_item_if.sink            item,
  gidu_result_if.source        result,
  input  logic                 epsilon_we,
  input  logic [31:0]          epsilon_wdata
);
  import gidu_pkg::*;

  localparam logic [SUM_W-1:0] DLIM = (WORD_BITS >= SUM_W) ? {SUM_W{1'b1}} :
                                      SUM_W'((65'd1 << WORD_BITS) - 65'd1);

  logic [31:0] epsilon_ratio;
  logic        adv;

  logic               v1;
  item_t              s1;
  logic               v2;
  item_t              s2;
  logic signed [64:0] prod_a;
  logic signed [63:0] prod_b;
  logic [62:0]        prod_eps;

  logic               vd   [0:NUM_W];
  div_t               dv   [0:NUM_W];
  ctx_t               cd   [0:NUM_W];

  logic               vsq  [0:ROOT_W];
  sqrt_t              sq1  [0:ROOT_W];
  sqrt_t              sq2  [0:ROOT_W];
  ctx2_t              cs   [0:ROOT_W];

  logic               vsel;
  ctx2_t              sel;
  logic [ARG_W-1:0]   a1, b1, a2, b2;

  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon_ratio <= EPS_RESET;
    end else if (epsilon_we) begin
      epsilon_ratio <= epsilon_wdata;
    end
  end

  function automatic logic [ARG_W-1:0] absd(input logic signed [35:0] x,
                                            input logic signed [35:0] y);
    logic signed [36:0] d;
    d = 37'(x) - 37'(y);
    return d[36] ? ARG_W'(-d) : ARG_W'(d);
  endfunction

  // Input and product stages.
  logic signed [32:0] hc;
  assign hc = -33'(s1.source_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= item.payload;
      s2       <= s1;
      prod_a   <= s1.query_x * hc;
      prod_b   <= s1.query_h * s1.source_x;
      prod_eps <= epsilon_ratio * s1.edge_len;
    end
  end

  // Numerator, denominator and degenerate test.
  logic signed [65:0] num;
  logic signed [33:0] den;
  logic [NUM_W-1:0]   num_mag;
  logic [DEN_W-1:0]   den_mag;

  always_comb begin
    num     = 66'(prod_a) + 66'(prod_b);
    den     = 34'(s2.query_h) - 34'(s2.source_y);
    num_mag = num[65] ? NUM_W'(-num) : NUM_W'(num);
    den_mag = den[33] ? DEN_W'(-den) : DEN_W'(den);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].rem   <= '0;
      dv[0].nq    <= num_mag;
      dv[0].den   <= den_mag;
      cd[0].item  <= s2;
      cd[0].deg   <= (den == '0) || (den_mag < {2'b00, prod_eps[62:32]});
      cd[0].qneg  <= num[65] ^ den[33];
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < NUM_W; gi++) begin : g_div
      gidu_div_cell u_cell (.clk(clk), .en(adv), .d_in(dv[gi]), .d_out(dv[gi+1]));
      always_ff @(posedge clk) begin
        if (adv) begin
          cd[gi+1] <= cd[gi];
        end
      end
    end
  endgenerate

  // Case selection once the quotient is known.
  item_t              it;
  logic signed [35:0] px, py, qx, qh, st, en, el;
  logic signed [65:0] ri;
  ctx2_t              sel_next;

  always_comb begin
    it = cd[NUM_W].item;
    px = 36'(it.source_x);
    py = 36'(it.source_y);
    qx = 36'(it.query_x);
    qh = 36'(it.query_h);
    st = 36'({1'b0, it.seg_start});
    en = 36'({1'b0, it.seg_end});
    el = 36'({1'b0, it.edge_len});
    ri = cd[NUM_W].qneg ? -$signed({2'b00, dv[NUM_W].nq}) : $signed({2'b00, dv[NUM_W].nq});
    a1 = '0;
    b1 = absd(py, 36'sd0);
    a2 = '0;
    b2 = '0;
    sel_next.inf     = it.window_infinite;
    sel_next.opcode  = it.opcode;
    sel_next.base    = it.base_distance;
    sel_next.lin     = '0;
    sel_next.r       = '0;
    sel_next.outside = 1'b0;
    unique case (it.opcode)
      OP_POINT: begin
        a1 = absd(qx, px);
        sel_next.outside = (qx < 36'sd0) || (qx > el);
      end
      OP_MAX: begin
        a1 = (absd(st, px) > absd(en, px)) ? absd(st, px) : absd(en, px);
      end
      OP_MIN: begin
        priority if (st > px) begin
          a1 = absd(st, px);
        end else if (en < px) begin
          a1 = absd(en, px);
        end else begin
          a1 = '0;
        end
      end
      default: begin
        if (cd[NUM_W].deg) begin
          priority if (qx <= st) begin
            a1 = absd(st, px);
            sel_next.lin = absd(qx, st);
            sel_next.r   = 32'(st);
          end else if (qx >= en) begin
            a1 = absd(en, px);
            sel_next.lin = absd(en, qx);
            sel_next.r   = 32'(en);
          end else begin
            a1 = absd(qx, px);
            sel_next.r   = 32'(qx);
          end
        end else begin
          priority if (ri < 66'(st)) begin
            a1 = absd(st, px);
            a2 = absd(st, qx);
            b2 = absd(qh, 36'sd0);
            sel_next.r = 32'(st);
          end else if (ri > 66'(en)) begin
            a1 = absd(en, px);
            a2 = absd(en, qx);
            b2 = absd(qh, 36'sd0);
            sel_next.r = 32'(en);
          end else begin
            a1 = absd(px, qx);
            b1 = absd(qh, py);
            sel_next.r = ri[31:0];
          end
        end
      end
    endcase
  end

  logic [ARG_W-1:0] ra1, rb1, ra2, rb2;

  always_ff @(posedge clk) begin
    if (adv) begin
      sel <= sel_next;
      ra1 <= a1;
      rb1 <= b1;
      ra2 <= a2;
      rb2 <= b2;
    end
  end

  // Sums of squares feed the two root chains.
  always_ff @(posedge clk) begin
    if (adv) begin
      sq1[0].rad  <= RAD_W'((2*ARG_W+1)'(ra1 * ra1)) + RAD_W'((2*ARG_W+1)'(rb1 * rb1));
      sq1[0].rem  <= '0;
      sq1[0].root <= '0;
      sq2[0].rad  <= RAD_W'((2*ARG_W+1)'(ra2 * ra2)) + RAD_W'((2*ARG_W+1)'(rb2 * rb2));
      sq2[0].rem  <= '0;
      sq2[0].root <= '0;
      cs[0]       <= sel;
    end
  end

  generate
    for (gi = 0; gi < ROOT_W; gi++) begin : g_sqrt
      gidu_sqrt_cell u_lane1 (.clk(clk), .en(adv), .d_in(sq1[gi]), .d_out(sq1[gi+1]));
      gidu_sqrt_cell u_lane2 (.clk(clk), .en(adv), .d_in(sq2[gi]), .d_out(sq2[gi+1]));
      always_ff @(posedge clk) begin
        if (adv) begin
          cs[gi+1] <= cs[gi];
        end
      end
    end
  endgenerate

  // Final sum, saturation and result register.
  ctx2_t            cf;
  logic [SUM_W-1:0] dsum;
  logic             sat;
  result_t          res_next;

  always_comb begin
    cf   = cs[ROOT_W];
    dsum = SUM_W'(cf.base) + SUM_W'(sq1[ROOT_W].root) + SUM_W'(sq2[ROOT_W].root) +
           SUM_W'(cf.lin);
    sat  = dsum > DLIM;
    if (cf.inf) begin
      res_next.distance       = DLIM[31:0];
      res_next.closest_offset = (cf.opcode == OP_CLOSEST) ? 32'sh7FFF_FFFF : '0;
      res_next.is_infinite    = 1'b1;
      res_next.status         = ST_OK;
    end else begin
      res_next.distance       = sat ? DLIM[31:0] : dsum[31:0];
      res_next.closest_offset = (cf.opcode == OP_CLOSEST) ? cf.r : '0;
      res_next.is_infinite    = 1'b0;
      priority if (cf.outside) begin
        res_next.status = ST_OUTSIDE;
      end else if (sat) begin
        res_next.status = ST_SAT;
      end else begin
        res_next.status = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.payload <= res_next;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      vsel         <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      v1           <= item.valid;
      v2           <= v1;
      vsel         <= vd[NUM_W];
      result.valid <= vsq[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0]  <= 1'b0;
      vsq[0] <= 1'b0;
    end else if (adv) begin
      vd[0]  <= v2;
      vsq[0] <= vsel;
    end
  end

  generate
    for (gi = 0; gi < NUM_W; gi++) begin : g_vd
      always_ff @(posedge clk) begin
        if (rst) begin
          vd[gi+1] <= 1'b0;
        end else if (adv) begin
          vd[gi+1] <= vd[gi];
        end
      end
    end
    for (gi = 0; gi < ROOT_W; gi++) begin : g_vsq
      always_ff @(posedge clk) begin
        if (rst) begin
          vsq[gi+1] <= 1'b0;
        end else if (adv) begin
          vsq[gi+1] <= vsq[gi];
        end
      end
    end
  endgenerate

endmodule

`default_nettype wire

### design/gidu_checker.sv
// ----------------------------------------------------------------------------
// Geodesic interval distance unit checker
// Port-level properties of the unit, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "geodesic_interval_distance_unit_defines.svh"

module gidu_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input gidu_pkg::result_t result_payload
);
  import gidu_pkg::*;

  `GIDU_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
  `GIDU_ASSERT_NEXT(a_payload_hold, result_valid && !result_ready, $stable(result_payload))
  `GIDU_ASSERT_NOW(a_stall_blocks_input, result_valid && !result_ready, !item_ready)
  `GIDU_ASSERT_NOW(a_infinite_ok, result_valid && result_payload.is_infinite, result_payload.status == ST_OK)
  `GIDU_ASSERT_RESET(a_reset_empty, rst, !result_valid)

endmodule

bind geodesic_interval_distance_unit gidu_checker u_gidu_checker (
  .clk(clk),
  .rst(rst),
  .item_ready(item.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .result_payload(result.payload)
);

`default_nettype wire
